// ===== rtl/csth_pkg.sv =====
// Shared types and constants for the client slot table with heartbeat.
`timescale 1ns / 1ps
`default_nettype none
package csth_pkg;

  localparam int TimeW = 32;
  localparam int AddrW = 48;
  localparam int MaxHb = 8;
  localparam int CntW = $clog2(MaxHb + 1);
  localparam logic [15:0] HbIntervalReset = 16'd5000;

  typedef enum logic [1:0] {
    KIND_HANDSHAKE  = 2'd0,
    KIND_DISCONNECT = 2'd1,
    KIND_HB_RECV    = 2'd2,
    KIND_TICK       = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REPLY_HANDSHAKE = 2'd0,
    REPLY_FULL      = 2'd1,
    REPLY_ACK       = 2'd2,
    REPLY_HEARTBEAT = 2'd3
  } reply_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [AddrW-1:0] peer_address;
    logic [2:0]       sender_slot;
    logic [15:0]      sequence_number;
    logic [15:0]      elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       reply_kind;
    logic [2:0]       slot;
    logic [AddrW-1:0] dest_address;
    logic [15:0]      echo_sequence;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic   load_item;
    logic   idx_clr;
    logic   idx_inc;
    logic   alloc;
    logic   disc;
    logic   recv;
    logic   time_add;
    logic   cnt_inc;
    logic   cnt_dec;
    logic   mark;
    logic   out_load;
    reply_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic hit;
    logic free;
    logic stale;
    logic sender_ok;
    logic out_free;
    logic cnt_full;
    logic cnt_zero;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/csth_datapath.sv =====
// Datapath: slot storage, time counter, scan index, heartbeat counter and output register.
`timescale 1ns / 1ps
`default_nettype none
module csth_datapath #(
  parameter int SLOT_COUNT = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [15:0]          cfg_wdata_i,
  input  csth_pkg::in_item_t  in_item_i,
  input  csth_pkg::cmd_t      cmd_i,
  output csth_pkg::sts_t      sts_o,
  input  wire                 out_stall_i,
  output logic                out_valid_o,
  output csth_pkg::out_item_t out_item_o
);
  import csth_pkg::*;

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  in_item_t            item_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [15:0]         interval_q;
  logic [TimeW-1:0]    cur_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                out_valid_q;
  out_item_t           out_q, out_d;

  logic [SLOT_COUNT-1:0] valid_q;
  logic [AddrW-1:0]      addr_q      [SLOT_COUNT];
  logic [TimeW-1:0]      sent_q      [SLOT_COUNT];
  logic [TimeW-1:0]      recv_q      [SLOT_COUNT];
  logic [TimeW-1:0]      connect_q   [SLOT_COUNT];

  logic [TimeW-1:0] age;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= HbIntervalReset;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load_item) begin
      if (in_item_i.kind == KIND_DISCONNECT || in_item_i.kind == KIND_HB_RECV) begin
        idx_d = IdxW'(in_item_i.sender_slot);
      end else begin
        idx_d = '0;
      end
    end else if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load_item) begin
      cnt_d = '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      cur_q <= '0;
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      if (cmd_i.time_add) begin
        cur_q <= cur_q + TimeW'(item_q.elapsed_ms);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        sent_q[i]    <= '0;
        recv_q[i]    <= '0;
        connect_q[i] <= '0;
      end
    end else begin
      if (cmd_i.alloc) begin
        valid_q[idx_q]   <= 1'b1;
        connect_q[idx_q] <= cur_q;
      end
      if (cmd_i.disc) begin
        valid_q[idx_q]   <= 1'b0;
        sent_q[idx_q]    <= '0;
        recv_q[idx_q]    <= '0;
        connect_q[idx_q] <= '0;
      end
      if (cmd_i.recv) begin
        recv_q[idx_q] <= cur_q;
      end
      if (cmd_i.mark) begin
        sent_q[idx_q] <= cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc) begin
      addr_q[idx_q] <= item_q.peer_address;
    end
  end

  assign age = cur_q - sent_q[idx_q];

  always_comb begin
    sts_o.idx_last  = (idx_q == IdxW'(SLOT_COUNT - 1));
    sts_o.hit       = valid_q[idx_q] && (addr_q[idx_q] == item_q.peer_address);
    sts_o.free      = !valid_q[idx_q];
    sts_o.stale     = valid_q[idx_q] && (age > TimeW'(interval_q));
    sts_o.sender_ok = int'(item_q.sender_slot) < SLOT_COUNT;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
    sts_o.cnt_full  = (cnt_q == CntW'(MaxHb));
    sts_o.cnt_zero  = (cnt_q == '0);
  end

  always_comb begin
    out_d.reply_kind    = cmd_i.out_kind;
    out_d.slot          = 3'(idx_q);
    out_d.dest_address  = item_q.peer_address;
    out_d.echo_sequence = '0;
    out_d.last          = 1'b1;
    case (cmd_i.out_kind)
      REPLY_HANDSHAKE: ;
      REPLY_FULL: begin
        out_d.slot = '0;
      end
      REPLY_ACK: begin
        out_d.dest_address  = addr_q[idx_q];
        out_d.echo_sequence = item_q.sequence_number;
      end
      REPLY_HEARTBEAT: begin
        out_d.dest_address = addr_q[idx_q];
        out_d.last         = (cnt_q == CntW'(1));
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ===== rtl/csth_ctrl.sv =====
// Controller state machine sequencing table scans and result emission.
`timescale 1ns / 1ps
`default_nettype none
module csth_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  wire [1:0]       in_kind_i,
  output logic            in_stall_o,
  input  csth_pkg::sts_t  sts_i,
  output csth_pkg::cmd_t  cmd_o
);
  import csth_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MATCH = 4'd1;
  localparam logic [3:0] S_FREE  = 4'd2;
  localparam logic [3:0] S_FULL  = 4'd3;
  localparam logic [3:0] S_DISC  = 4'd4;
  localparam logic [3:0] S_RECV  = 4'd5;
  localparam logic [3:0] S_TADD  = 4'd6;
  localparam logic [3:0] S_COUNT = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_kind = REPLY_HANDSHAKE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          unique case (in_kind_i)
            KIND_HANDSHAKE:  state_d = S_MATCH;
            KIND_DISCONNECT: state_d = S_DISC;
            KIND_HB_RECV:    state_d = S_RECV;
            default:         state_d = S_TADD;
          endcase
        end
      end
      S_MATCH: begin
        if (sts_i.hit) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_FREE;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_FREE: begin
        if (sts_i.free) begin
          if (sts_i.out_free) begin
            cmd_o.alloc    = 1'b1;
            cmd_o.out_load = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.idx_last) begin
          state_d = S_FULL;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_FULL: begin
        cmd_o.out_kind = REPLY_FULL;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DISC: begin
        cmd_o.out_kind = REPLY_ACK;
        if (!sts_i.sender_ok) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.disc     = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RECV: begin
        cmd_o.recv = sts_i.sender_ok;
        state_d = S_IDLE;
      end
      S_TADD: begin
        cmd_o.time_add = 1'b1;
        state_d = S_COUNT;
      end
      S_COUNT: begin
        // first pass counts stale slots so the final heartbeat can be flagged
        cmd_o.cnt_inc = sts_i.stale && !sts_i.cnt_full;
        if (sts_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_EMIT;
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      S_EMIT: begin
        cmd_o.out_kind = REPLY_HEARTBEAT;
        if (sts_i.cnt_zero) begin
          state_d = S_IDLE;
        end else if (sts_i.stale) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.mark     = 1'b1;
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.idx_inc  = 1'b1;
          end
        end else begin
          cmd_o.idx_inc = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/client_slot_table_with_heartbeat.sv =====
// Handshake: match scan, then free-slot scan, one slot a cycle; a tick runs a time add, a counting
// scan and an emit scan. Handshake, disconnect and tick replies also wait out any output stall.
// Throughput: one item at a time; the next item is accepted once the controller is idle again.
// Reset: all slots invalid, timestamps and time counter zero, heartbeat interval 5000 ms.
// Top level of the client slot table with heartbeat.
`timescale 1ns / 1ps
`default_nettype none
module client_slot_table_with_heartbeat #(
  parameter int SLOT_COUNT = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [15:0]          cfg_wdata_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  csth_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output csth_pkg::out_item_t out_item_o
);
  import csth_pkg::*;

  cmd_t cmd;
  sts_t sts;

  csth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  csth_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ===== tb/client_slot_table_with_heartbeat_test.sv =====
// Self-checking testbench for the client slot table: predicts replies per item and compares them.
`timescale 1ns / 1ps
module client_slot_table_with_heartbeat_test;
  import csth_pkg::*;

  localparam int Slots = 8;
  localparam int PoolSize = 10;
  localparam int PhaseItems = 80;
  localparam int SettleCycles = 40;
  localparam int CycleLimit = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  logic calm;
  int unsigned cycles;
  logic [AddrW-1:0] addr_pool[PoolSize];

  client_slot_table_with_heartbeat #(
    .SLOT_COUNT(Slots)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  class slot_table_model;
    logic             valid[Slots];
    logic             written[Slots];
    logic [AddrW-1:0] address[Slots];
    logic [TimeW-1:0] sent_at[Slots];
    logic [TimeW-1:0] heard_at[Slots];
    logic [TimeW-1:0] joined_at[Slots];
    logic [TimeW-1:0] now_ms;
    logic [15:0]      interval;
    out_item_t        replies_due[$];
    int               mismatches;

    function new();
      for (int i = 0; i < Slots; i++) begin
        valid[i] = 1'b0;
        written[i] = 1'b0;
        address[i] = '0;
        sent_at[i] = '0;
        heard_at[i] = '0;
        joined_at[i] = '0;
      end
      now_ms = '0;
      interval = HbIntervalReset;
      mismatches = 0;
    endfunction

    function void set_interval(logic [15:0] v);
      interval = v;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void queue_reply(reply_e kind, logic [2:0] slot, logic [AddrW-1:0] dest,
                              logic [15:0] seq, logic last);
      out_item_t r;
      r.reply_kind = kind;
      r.slot = slot;
      r.dest_address = dest;
      r.echo_sequence = seq;
      r.last = last;
      replies_due.push_back(r);
    endfunction

    function void accept_item(in_item_t it);
      int hit;
      int cnt;
      int s;
      logic [2:0] stale[Slots];
      logic [TimeW-1:0] age;
      hit = -1;
      cnt = 0;
      s = int'(it.sender_slot);
      case (it.kind)
        KIND_HANDSHAKE: begin
          for (int i = 0; i < Slots; i++)
            if (hit < 0 && valid[i] && address[i] == it.peer_address) hit = i;
          if (hit < 0) begin
            for (int i = 0; i < Slots; i++)
              if (hit < 0 && !valid[i]) hit = i;
            if (hit < 0) begin
              queue_reply(REPLY_FULL, 3'd0, it.peer_address, 16'd0, 1'b1);
            end else begin
              address[hit] = it.peer_address;
              valid[hit] = 1'b1;
              written[hit] = 1'b1;
              joined_at[hit] = now_ms;
            end
          end
          if (hit >= 0) queue_reply(REPLY_HANDSHAKE, 3'(hit), it.peer_address, 16'd0, 1'b1);
        end
        KIND_DISCONNECT: begin
          queue_reply(REPLY_ACK, it.sender_slot, address[s], it.sequence_number, 1'b1);
          valid[s] = 1'b0;
          sent_at[s] = '0;
          heard_at[s] = '0;
          joined_at[s] = '0;
        end
        KIND_HB_RECV: begin
          heard_at[s] = now_ms;
        end
        default: begin
          now_ms = now_ms + TimeW'(it.elapsed_ms);
          for (int i = 0; i < Slots; i++) begin
            age = now_ms - sent_at[i];
            if (cnt < MaxHb && valid[i] && age > {16'd0, interval}) begin
              sent_at[i] = now_ms;
              stale[cnt] = 3'(i);
              cnt++;
            end
          end
          for (int k = 0; k < cnt; k++)
            queue_reply(REPLY_HEARTBEAT, stale[k], address[stale[k]], 16'd0, cnt == k + 1);
        end
      endcase
    endfunction

    function void match_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: kind=%0d slot=%0d addr=%h seq=%h last=%b",
                   got.reply_kind, got.slot, got.dest_address, got.echo_sequence, got.last);
        return;
      end
      want = replies_due.pop_front();
      if (got.reply_kind !== want.reply_kind || got.slot !== want.slot ||
          got.dest_address !== want.dest_address ||
          got.echo_sequence !== want.echo_sequence || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: expected kind=%0d slot=%0d addr=%h seq=%h last=%b,",
                   want.reply_kind, want.slot, want.dest_address, want.echo_sequence,
                   want.last, " got kind=%0d slot=%0d addr=%h seq=%h last=%b",
                   got.reply_kind, got.slot, got.dest_address,
                   got.echo_sequence, got.last);
      end
    endfunction
  endclass

  slot_table_model table_model;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(0, 99) < 31);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) table_model.match_reply(out_item_o);
  end

  function automatic logic [AddrW-1:0] rand_addr();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    return wide[AddrW-1:0];
  endfunction

  function automatic in_item_t noise_item();
    in_item_t it;
    it.kind = kind_e'($urandom_range(0, 3));
    it.peer_address = rand_addr();
    it.sender_slot = 3'($urandom_range(0, 7));
    it.sequence_number = 16'($urandom());
    it.elapsed_ms = 16'($urandom());
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned roll;
    int unsigned span;
    it = noise_item();
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      it.kind = KIND_HANDSHAKE;
      if ($urandom_range(0, 9) < 7) it.peer_address = addr_pool[$urandom_range(0, PoolSize - 1)];
    end else if (roll < 55) begin
      it.kind = KIND_DISCONNECT;
      // never disconnect a slot whose address was never written
      if (!table_model.written[it.sender_slot]) it.kind = KIND_HANDSHAKE;
    end else if (roll < 70) begin
      it.kind = KIND_HB_RECV;
    end else begin
      it.kind = KIND_TICK;
      span = 2 * int'(table_model.interval) + 2;
      if (span > 65535) span = 65535;
      case ($urandom_range(0, 3))
        0, 1: it.elapsed_ms = 16'($urandom_range(0, span));
        2: it.elapsed_ms = 16'($urandom());
        default: it.elapsed_ms = 16'($urandom_range(0, 15));
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    while (!calm && $urandom_range(0, 99) < 31) begin
      in_valid_i <= 1'b0;
      in_item_i <= noise_item();
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    table_model.accept_item(it);
  endtask

  task automatic send_fields(input kind_e kind, input logic [AddrW-1:0] addr,
                             input logic [2:0] slot, input logic [15:0] seq,
                             input logic [15:0] elapsed);
    in_item_t it;
    it.kind = kind;
    it.peer_address = addr;
    it.sender_slot = slot;
    it.sequence_number = seq;
    it.elapsed_ms = elapsed;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (table_model.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_interval(input logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_model.set_interval(v);
  endtask

  initial begin
    logic [15:0] phase_interval[5];
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    out_stall_i <= 1'b0;
    calm = 1'b0;
    cycles = 0;
    table_model = new();
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < PoolSize; i++) addr_pool[i] = rand_addr();
    phase_interval[0] = 16'd0;
    phase_interval[1] = 16'hFFFF;
    phase_interval[2] = 16'($urandom_range(1, 9000));
    phase_interval[3] = 16'd37;
    phase_interval[4] = HbIntervalReset;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the table, known peer, then full
    send_fields(KIND_HANDSHAKE, addr_pool[0], 3'd7, 16'hFFFF, 16'hFFFF);
    send_fields(KIND_HANDSHAKE, addr_pool[1], 3'd0, 16'd0, 16'd0);
    send_fields(KIND_HANDSHAKE, addr_pool[0], 3'd5, 16'h1234, 16'd9);
    for (int i = 2; i < Slots; i++)
      send_fields(KIND_HANDSHAKE, addr_pool[i], 3'($urandom()), 16'($urandom()), 16'($urandom()));
    send_fields(KIND_HANDSHAKE, rand_addr(), 3'd2, 16'd0, 16'd0);
    send_fields(KIND_HB_RECV, '1, 3'd7, 16'd0, 16'd0);
    send_fields(KIND_HB_RECV, '0, 3'd0, 16'd0, 16'd0);
    // every slot stale at once, then a tick that moves nothing
    send_fields(KIND_TICK, '0, 3'd0, 16'd0, 16'hFFFF);
    send_fields(KIND_TICK, '1, 3'd7, 16'hFFFF, 16'd0);
    // disconnect, disconnect of a freed slot, reuse
    send_fields(KIND_DISCONNECT, '0, 3'd3, 16'hFFFF, 16'd0);
    send_fields(KIND_DISCONNECT, '1, 3'd3, 16'd0, 16'hFFFF);
    send_fields(KIND_HANDSHAKE, addr_pool[8], 3'd0, 16'd0, 16'd0);
    // age exactly at the interval is not stale, one more ms is
    send_fields(KIND_TICK, '0, 3'd0, 16'd0, 16'd5000);
    send_fields(KIND_TICK, '0, 3'd0, 16'd0, 16'd1);
    send_fields(KIND_DISCONNECT, '0, 3'd7, 16'($urandom()), 16'd0);
    send_fields(KIND_HANDSHAKE, addr_pool[1], 3'd1, 16'd0, 16'd0);

    for (int p = 0; p < 5; p++) begin
      write_interval(phase_interval[p]);
      calm = (p == 2);
      for (int n = 0; n < PhaseItems; n++) send_item(random_item());
      calm = 1'b0;
    end
    drain();

    if (table_model.mismatches == 0 && table_model.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/csth_pkg.sv
rtl/csth_datapath.sv
rtl/csth_ctrl.sv
rtl/client_slot_table_with_heartbeat.sv
tb/client_slot_table_with_heartbeat_test.sv
